>>> design/tsx_pkg.sv
package tsx_pkg;

   localparam int DMEM_WORDS  = 1024;
   localparam int DMEM_AW     = $clog2(DMEM_WORDS);
   localparam int REG_COUNT   = 16;
   localparam int REG_AW      = $clog2(REG_COUNT);
   localparam int NUM_RESULTS = 10;
   localparam int RES_AW      = $clog2(NUM_RESULTS);

   localparam logic [REG_AW-1:0] SP_REG = 4'd13;
   localparam logic [REG_AW-1:0] LR_REG = 4'd14;
   localparam logic [REG_AW-1:0] PC_REG = 4'd15;

   localparam logic [3:0] COND_EQ = 4'd0;
   localparam logic [3:0] COND_NE = 4'd1;
   localparam logic [3:0] COND_CS = 4'd2;
   localparam logic [3:0] COND_CC = 4'd3;
   localparam logic [3:0] COND_MI = 4'd4;
   localparam logic [3:0] COND_PL = 4'd5;
   localparam logic [3:0] COND_VS = 4'd6;
   localparam logic [3:0] COND_VC = 4'd7;
   localparam logic [3:0] COND_HI = 4'd8;
   localparam logic [3:0] COND_LS = 4'd9;
   localparam logic [3:0] COND_GE = 4'd10;
   localparam logic [3:0] COND_LT = 4'd11;
   localparam logic [3:0] COND_GT = 4'd12;
   localparam logic [3:0] COND_LE = 4'd13;
   localparam logic [3:0] COND_AL = 4'd14;

   localparam logic [4:0] PICK_EXTRA = 5'd8;

   typedef enum logic [3:0] {
      OP_NOP, OP_ADDHI, OP_CMPHI, OP_MOVHI, OP_BX, OP_PUSH, OP_POP, OP_ADDS,
      OP_MOVI, OP_LDRLIT, OP_STR, OP_LDR, OP_STRB, OP_LDRB, OP_BCOND, OP_B
   } op_type;

   typedef struct packed {
      op_type            opc;
      logic [REG_AW-1:0] a_idx;
      logic [REG_AW-1:0] b_idx;
      logic [REG_AW-1:0] dst;
      logic              sub;
      logic              use_imm;
      logic [31:0]       imm;
      logic [8:0]        mask;
      logic [3:0]        cond;
   } dec_type;

   typedef struct packed {
      logic n;
      logic z;
      logic c;
      logic v;
      logic t;
   } flag_type;

endpackage

>>> design/tsx_req_if.sv
interface tsx_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [15:0] instr;
   logic [9:0]  load_index;
   logic [31:0] load_word;

   modport source (output valid, action, instr, load_index, load_word, input ready);
   modport sink (input valid, action, instr, load_index, load_word, output ready);
endinterface

>>> design/tsx_rsp_if.sv
interface tsx_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] next_pc;
   logic        flag_n;
   logic        flag_z;
   logic        flag_c;
   logic        flag_v;
   logic        thumb_state;
   logic        reg_written;
   logic [3:0]  reg_index;
   logic [31:0] reg_value;
   logic        last;

   modport source (output valid, next_pc, flag_n, flag_z, flag_c, flag_v, thumb_state,
                   reg_written, reg_index, reg_value, last, input ready);
   modport sink (input valid, next_pc, flag_n, flag_z, flag_c, flag_v, thumb_state,
                 reg_written, reg_index, reg_value, last, output ready);
endinterface

>>> design/tsx_ram.sv
module tsx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

>>> design/tsx_decode.sv
module tsx_decode (
   input  logic [15:0]      instr,
   output tsx_pkg::dec_type dec
);
   logic [2:0] lo0, lo3, lo6, r8;
   logic [3:0] hd, hs;
   logic [7:0] imm8;
   logic [4:0] imm5;
   logic [8:0] regs;
   logic [3:0] cnt;

   assign lo0  = instr[2:0];
   assign lo3  = instr[5:3];
   assign lo6  = instr[8:6];
   assign r8   = instr[10:8];
   assign hd   = {instr[7], instr[2:0]};
   assign hs   = {instr[6], instr[5:3]};
   assign imm8 = instr[7:0];
   assign imm5 = instr[10:6];
   assign regs = instr[8:0];

   always_comb begin
      cnt = '0;
      for (int i = 0; i < 9; i++) begin
         cnt = cnt + 4'(regs[i]);
      end
   end

   always_comb begin
      dec = '0;
      dec.opc  = tsx_pkg::OP_NOP;
      dec.mask = regs;
      dec.cond = instr[11:8];
      if (instr[15:8] == 8'h44) begin
         dec.opc = tsx_pkg::OP_ADDHI; dec.a_idx = hd; dec.b_idx = hs; dec.dst = hd;
      end else if (instr[15:8] == 8'h45) begin
         dec.opc = tsx_pkg::OP_CMPHI; dec.a_idx = hd; dec.b_idx = hs; dec.sub = 1'b1;
      end else if (instr[15:8] == 8'h46) begin
         dec.opc = tsx_pkg::OP_MOVHI; dec.b_idx = hs; dec.dst = hd;
      end else if (instr[15:8] == 8'h47) begin
         dec.opc = tsx_pkg::OP_BX; dec.b_idx = hs;
      end else if (instr[15:9] == 7'b1011010) begin
         dec.opc = tsx_pkg::OP_PUSH; dec.a_idx = tsx_pkg::SP_REG;
         dec.sub = 1'b1; dec.use_imm = 1'b1; dec.imm = {26'd0, cnt, 2'b00};
      end else if (instr[15:9] == 7'b1011110) begin
         dec.opc = tsx_pkg::OP_POP; dec.a_idx = tsx_pkg::SP_REG;
      end else if (instr[15:11] == 5'b00011) begin
         dec.opc = tsx_pkg::OP_ADDS; dec.a_idx = {1'b0, lo3}; dec.b_idx = {1'b0, lo6};
         dec.dst = {1'b0, lo0}; dec.sub = instr[9]; dec.use_imm = instr[10];
         dec.imm = {29'd0, lo6};
      end else if (instr[15:11] == 5'b00100) begin
         dec.opc = tsx_pkg::OP_MOVI; dec.dst = {1'b0, r8}; dec.imm = {24'd0, imm8};
      end else if (instr[15:12] == 4'b0011) begin
         dec.opc = tsx_pkg::OP_ADDS; dec.a_idx = {1'b0, r8}; dec.dst = {1'b0, r8};
         dec.sub = instr[11]; dec.use_imm = 1'b1; dec.imm = {24'd0, imm8};
      end else if (instr[15:11] == 5'b01001) begin
         dec.opc = tsx_pkg::OP_LDRLIT; dec.dst = {1'b0, r8};
         dec.use_imm = 1'b1; dec.imm = {22'd0, imm8, 2'b00};
      end else if (instr[15:13] == 3'b011) begin
         case (instr[12:11])
            2'b00:   dec.opc = tsx_pkg::OP_STR;
            2'b01:   dec.opc = tsx_pkg::OP_LDR;
            2'b10:   dec.opc = tsx_pkg::OP_STRB;
            default: dec.opc = tsx_pkg::OP_LDRB;
         endcase
         dec.a_idx = {1'b0, lo3}; dec.b_idx = {1'b0, lo0}; dec.dst = {1'b0, lo0};
         dec.use_imm = 1'b1;
         dec.imm = instr[12] ? {27'd0, imm5} : {25'd0, imm5, 2'b00};
      end else if (instr[15:12] == 4'b1101) begin
         dec.opc = tsx_pkg::OP_BCOND; dec.use_imm = 1'b1;
         dec.imm = {{23{imm8[7]}}, imm8, 1'b0};
      end else if (instr[15:11] == 5'b11100) begin
         dec.opc = tsx_pkg::OP_B; dec.use_imm = 1'b1;
         dec.imm = {{20{instr[10]}}, instr[10:0], 1'b0};
      end
   end
endmodule

>>> design/thumb_subset_execute_unit_core.sv
// Executes one Thumb instruction (or one data memory preload) per request item and
// answers with one response item per register write (a single item when nothing is
// written), the final one marked last; each response carries the PC and flags as they
// stand after the whole instruction. After reset the unit clears all DMEM_WORDS words of
// the data memory and the register file before it takes a request. An instruction then
// passes operand reads A and B and the shared adder in EXEC; loads and byte stores add a
// LOAD step, and PUSH and POP a read and a write step per listed register, as register
// file and data memory each have one read port. Response items then go out as rsp ready
// allows. A preload writes the data memory on acceptance and goes to its response.
module thumb_subset_execute_unit_core (
   input  logic      clock,
   input  logic      reset,
   tsx_req_if.sink   req_chan,
   tsx_rsp_if.source rsp_chan
);
   typedef enum logic [10:0] {
      ST_CLEAR  = 11'b00000000001,
      ST_IDLE   = 11'b00000000010,
      ST_RDA    = 11'b00000000100,
      ST_RDB    = 11'b00000001000,
      ST_EXEC   = 11'b00000010000,
      ST_LOAD   = 11'b00000100000,
      ST_PUSHRD = 11'b00001000000,
      ST_PUSHWR = 11'b00010000000,
      ST_POPRD  = 11'b00100000000,
      ST_POPWR  = 11'b01000000000,
      ST_OUT    = 11'b10000000000
   } state_type;

   localparam int DAW   = tsx_pkg::DMEM_AW;
   localparam int RAW   = tsx_pkg::REG_AW;
   localparam int RES_W = tsx_pkg::RES_AW;

   state_type          state_ff, state_in;
   logic [DAW-1:0]     clr_ff, clr_in;
   logic [31:0]        pc_ff, pc_in;
   tsx_pkg::flag_type  flags_ff, flags_in;
   logic [15:0]        instr_ff, instr_in;
   logic [31:0]        opa_ff, opa_in;
   logic [31:0]        opb_ff, opb_in;
   logic [31:0]        addr_ff, addr_in;
   logic [8:0]         mask_ff, mask_in;
   logic [4:0]         cur_ff, cur_in;
   logic [RES_W-1:0]   wcnt_ff, wcnt_in;
   logic [RES_W-1:0]   rdk_ff, rdk_in;
   logic [RAW-1:0]     widx_ff [tsx_pkg::NUM_RESULTS];
   logic [31:0]        wval_ff [tsx_pkg::NUM_RESULTS];

   tsx_pkg::dec_type   dec;
   logic               rf_we;
   logic [RAW-1:0]     rf_waddr, rf_raddr;
   logic [31:0]        rf_wdata, rf_rdata;
   logic               dm_we;
   logic [DAW-1:0]     dm_waddr, dm_raddr;
   logic [31:0]        dm_wdata, dm_rdata;

   logic [31:0]        b_val, add_a, add_b, add_bx, res;
   logic               add_sub;
   logic [32:0]        sum;
   logic               wr_en, jx_en;
   logic [RAW-1:0]     wr_idx;
   logic [31:0]        wr_val, jx_val, ld_val, ld_rot;
   logic [4:0]         pick;
   logic               cond_ok;
   logic               out_last;

   tsx_decode u_decode (.instr(instr_ff), .dec(dec));

   tsx_ram #(.WIDTH(32), .DEPTH(tsx_pkg::REG_COUNT)) u_regfile (
      .clock(clock), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
      .raddr(rf_raddr), .rdata(rf_rdata)
   );

   tsx_ram #(.WIDTH(32), .DEPTH(tsx_pkg::DMEM_WORDS)) u_dmem (
      .clock(clock), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
      .raddr(dm_raddr), .rdata(dm_rdata)
   );

   function automatic logic [31:0] rot_right_bytes(input logic [31:0] v, input logic [1:0] k);
      logic [31:0] r;
      case (k)
         2'd1:    r = {v[7:0], v[31:8]};
         2'd2:    r = {v[15:0], v[31:16]};
         2'd3:    r = {v[23:0], v[31:24]};
         default: r = v;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] rot_left_bytes(input logic [31:0] v, input logic [1:0] k);
      logic [31:0] r;
      case (k)
         2'd1:    r = {v[23:0], v[31:24]};
         2'd2:    r = {v[15:0], v[31:16]};
         2'd3:    r = {v[7:0], v[31:8]};
         default: r = v;
      endcase
      return r;
   endfunction

   function automatic logic [DAW-1:0] word_of(input logic [31:0] a);
      return a[DAW+1:2];
   endfunction

   assign b_val  = (dec.b_idx == tsx_pkg::PC_REG) ? pc_ff : rf_rdata;
   assign add_bx = add_b ^ {32{add_sub}};
   assign sum    = {1'b0, add_a} + {1'b0, add_bx} + {32'd0, add_sub};
   assign res    = sum[31:0];

   always_comb begin
      add_a   = opa_ff;
      add_b   = dec.use_imm ? dec.imm : b_val;
      add_sub = dec.sub;
      case (dec.opc)
         tsx_pkg::OP_LDRLIT: begin
            add_a = {pc_ff[31:2], 2'b00};
            add_b = dec.imm + {29'd0, pc_ff[1], 2'b00};
         end
         tsx_pkg::OP_BCOND, tsx_pkg::OP_B: begin
            add_a = pc_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      case (dec.cond)
         tsx_pkg::COND_EQ: cond_ok = flags_ff.z;
         tsx_pkg::COND_NE: cond_ok = !flags_ff.z;
         tsx_pkg::COND_CS: cond_ok = flags_ff.c;
         tsx_pkg::COND_CC: cond_ok = !flags_ff.c;
         tsx_pkg::COND_MI: cond_ok = flags_ff.n;
         tsx_pkg::COND_PL: cond_ok = !flags_ff.n;
         tsx_pkg::COND_VS: cond_ok = flags_ff.v;
         tsx_pkg::COND_VC: cond_ok = !flags_ff.v;
         tsx_pkg::COND_HI: cond_ok = flags_ff.c && !flags_ff.z;
         tsx_pkg::COND_LS: cond_ok = !flags_ff.c || flags_ff.z;
         tsx_pkg::COND_GE: cond_ok = flags_ff.n == flags_ff.v;
         tsx_pkg::COND_LT: cond_ok = flags_ff.n != flags_ff.v;
         tsx_pkg::COND_GT: cond_ok = !flags_ff.z && (flags_ff.n == flags_ff.v);
         tsx_pkg::COND_LE: cond_ok = flags_ff.z || (flags_ff.n != flags_ff.v);
         tsx_pkg::COND_AL: cond_ok = 1'b1;
         default:          cond_ok = 1'b0;
      endcase
   end

   always_comb begin
      pick = tsx_pkg::PICK_EXTRA;
      for (int i = 8; i >= 0; i--) begin
         if (mask_ff[i]) begin
            pick = 5'(i);
         end
      end
   end

   assign ld_rot = rot_right_bytes(dm_rdata, addr_ff[1:0]);

   always_comb begin
      case (dec.opc)
         tsx_pkg::OP_LDR:  ld_val = ld_rot;
         tsx_pkg::OP_LDRB: ld_val = {24'd0, ld_rot[7:0]};
         default:          ld_val = dm_rdata;
      endcase
   end

   assign out_last = (wcnt_ff == '0) || ((rdk_ff + 1'b1) == wcnt_ff);

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      pc_in    = pc_ff;
      flags_in = flags_ff;
      instr_in = instr_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      addr_in  = addr_ff;
      mask_in  = mask_ff;
      cur_in   = cur_ff;
      wcnt_in  = wcnt_ff;
      rdk_in   = rdk_ff;
      rf_we    = 1'b0;
      rf_waddr = '0;
      rf_wdata = '0;
      rf_raddr = '0;
      dm_we    = 1'b0;
      dm_waddr = '0;
      dm_wdata = '0;
      dm_raddr = '0;
      wr_en    = 1'b0;
      wr_idx   = '0;
      wr_val   = '0;
      jx_en    = 1'b0;
      jx_val   = '0;

      case (state_ff)
         ST_CLEAR: begin
            rf_we    = 1'b1;
            rf_waddr = clr_ff[RAW-1:0];
            dm_we    = 1'b1;
            dm_waddr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               wcnt_in = '0;
               rdk_in  = '0;
               if (req_chan.action) begin
                  dm_we    = 1'b1;
                  dm_waddr = DAW'(req_chan.load_index);
                  dm_wdata = req_chan.load_word;
                  state_in = ST_OUT;
               end else begin
                  instr_in = req_chan.instr;
                  pc_in    = pc_ff + 32'd2;
                  state_in = ST_RDA;
               end
            end
         end
         ST_RDA: begin
            rf_raddr = dec.a_idx;
            state_in = ST_RDB;
         end
         ST_RDB: begin
            opa_in   = (dec.a_idx == tsx_pkg::PC_REG) ? pc_ff : rf_rdata;
            rf_raddr = dec.b_idx;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_OUT;
            opb_in   = b_val;
            case (dec.opc)
               tsx_pkg::OP_ADDHI: begin
                  wr_en = 1'b1; wr_idx = dec.dst; wr_val = res;
               end
               tsx_pkg::OP_CMPHI, tsx_pkg::OP_ADDS: begin
                  wr_en      = dec.opc == tsx_pkg::OP_ADDS;
                  wr_idx     = dec.dst;
                  wr_val     = res;
                  flags_in.n = res[31];
                  flags_in.z = res == '0;
                  flags_in.c = sum[32];
                  flags_in.v = (~(add_a[31] ^ add_bx[31])) & (add_a[31] ^ res[31]);
               end
               tsx_pkg::OP_MOVHI: begin
                  wr_en = 1'b1; wr_idx = dec.dst; wr_val = b_val;
               end
               tsx_pkg::OP_BX: begin
                  jx_en = 1'b1; jx_val = b_val;
               end
               tsx_pkg::OP_MOVI: begin
                  wr_en      = 1'b1;
                  wr_idx     = dec.dst;
                  wr_val     = dec.imm;
                  flags_in.n = 1'b0;
                  flags_in.z = dec.imm == '0;
               end
               tsx_pkg::OP_LDRLIT, tsx_pkg::OP_LDR, tsx_pkg::OP_LDRB, tsx_pkg::OP_STRB: begin
                  addr_in  = res;
                  dm_raddr = word_of(res);
                  state_in = ST_LOAD;
               end
               tsx_pkg::OP_STR: begin
                  dm_we    = 1'b1;
                  dm_waddr = word_of(res);
                  dm_wdata = rot_left_bytes(b_val, res[1:0]);
               end
               tsx_pkg::OP_BCOND, tsx_pkg::OP_B: begin
                  wr_en  = (dec.opc == tsx_pkg::OP_B) || cond_ok;
                  wr_idx = tsx_pkg::PC_REG;
                  wr_val = res;
               end
               tsx_pkg::OP_PUSH: begin
                  addr_in  = res;
                  opb_in   = res;
                  mask_in  = dec.mask;
                  state_in = ST_PUSHRD;
               end
               tsx_pkg::OP_POP: begin
                  addr_in  = opa_ff;
                  mask_in  = dec.mask;
                  state_in = ST_POPRD;
               end
               default: begin
               end
            endcase
         end
         ST_LOAD: begin
            state_in = ST_OUT;
            if (dec.opc == tsx_pkg::OP_STRB) begin
               dm_we    = 1'b1;
               dm_waddr = word_of(addr_ff);
               dm_wdata = dm_rdata;
               case (addr_ff[1:0])
                  2'd0:    dm_wdata[7:0]   = opb_ff[7:0];
                  2'd1:    dm_wdata[15:8]  = opb_ff[7:0];
                  2'd2:    dm_wdata[23:16] = opb_ff[7:0];
                  default: dm_wdata[31:24] = opb_ff[7:0];
               endcase
            end else begin
               wr_en      = 1'b1;
               wr_idx     = dec.dst;
               wr_val     = ld_val;
               flags_in.n = ld_val[31];
               flags_in.z = ld_val == '0;
            end
         end
         ST_PUSHRD: begin
            if (mask_ff == '0) begin
               wr_en    = 1'b1;
               wr_idx   = tsx_pkg::SP_REG;
               wr_val   = opb_ff;
               state_in = ST_OUT;
            end else begin
               rf_raddr = (pick == tsx_pkg::PICK_EXTRA) ? tsx_pkg::LR_REG : pick[RAW-1:0];
               mask_in  = mask_ff & ~(9'd1 << pick);
               state_in = ST_PUSHWR;
            end
         end
         ST_PUSHWR: begin
            dm_we    = 1'b1;
            dm_waddr = word_of(addr_ff);
            dm_wdata = rf_rdata;
            addr_in  = addr_ff + 32'd4;
            state_in = ST_PUSHRD;
         end
         ST_POPRD: begin
            if (mask_ff == '0) begin
               wr_en    = 1'b1;
               wr_idx   = tsx_pkg::SP_REG;
               wr_val   = addr_ff;
               state_in = ST_OUT;
            end else begin
               dm_raddr = word_of(addr_ff);
               cur_in   = pick;
               mask_in  = mask_ff & ~(9'd1 << pick);
               state_in = ST_POPWR;
            end
         end
         ST_POPWR: begin
            if (cur_ff == tsx_pkg::PICK_EXTRA) begin
               jx_en  = 1'b1;
               jx_val = dm_rdata;
            end else begin
               wr_en  = 1'b1;
               wr_idx = cur_ff[RAW-1:0];
               wr_val = dm_rdata;
            end
            addr_in  = addr_ff + 32'd4;
            state_in = ST_POPRD;
         end
         ST_OUT: begin
            if (rsp_chan.ready) begin
               rdk_in = rdk_ff + 1'b1;
               if (out_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (jx_en) begin
         wr_en      = 1'b1;
         wr_idx     = tsx_pkg::PC_REG;
         flags_in.t = jx_val[0];
         wr_val     = jx_val[0] ? {jx_val[31:1], 1'b0} : {jx_val[31:2], 2'b00};
      end
      if (wr_en) begin
         wcnt_in = wcnt_ff + 1'b1;
         if (wr_idx == tsx_pkg::PC_REG) begin
            pc_in = wr_val;
         end else begin
            rf_we    = 1'b1;
            rf_waddr = wr_idx;
            rf_wdata = wr_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         pc_ff    <= '0;
         flags_ff <= '{n: 1'b0, z: 1'b0, c: 1'b0, v: 1'b0, t: 1'b1};
         wcnt_ff  <= '0;
         rdk_ff   <= '0;
         mask_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pc_ff    <= pc_in;
         flags_ff <= flags_in;
         wcnt_ff  <= wcnt_in;
         rdk_ff   <= rdk_in;
         mask_ff  <= mask_in;
      end
      instr_ff <= instr_in;
      opa_ff   <= opa_in;
      opb_ff   <= opb_in;
      addr_ff  <= addr_in;
      cur_ff   <= cur_in;
      if (wr_en) begin
         widx_ff[wcnt_ff] <= wr_idx;
         wval_ff[wcnt_ff] <= wr_val;
      end
   end

   assign req_chan.ready       = state_ff == ST_IDLE;
   assign rsp_chan.valid       = state_ff == ST_OUT;
   assign rsp_chan.next_pc     = pc_ff;
   assign rsp_chan.flag_n      = flags_ff.n;
   assign rsp_chan.flag_z      = flags_ff.z;
   assign rsp_chan.flag_c      = flags_ff.c;
   assign rsp_chan.flag_v      = flags_ff.v;
   assign rsp_chan.thumb_state = flags_ff.t;
   assign rsp_chan.reg_written = wcnt_ff != '0;
   assign rsp_chan.reg_index   = (wcnt_ff != '0) ? widx_ff[rdk_ff] : '0;
   assign rsp_chan.reg_value   = (wcnt_ff != '0) ? wval_ff[rdk_ff] : '0;
   assign rsp_chan.last        = out_last;

   a_wcnt_bound: assert property (@(posedge clock) disable iff (reset)
      wcnt_ff <= RES_W'(tsx_pkg::NUM_RESULTS))
      else $error("result count overflow");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last) |=> state_ff == ST_IDLE)
      else $error("last item did not return to idle");

   a_pc_advance: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && !req_chan.action)
      |=> pc_ff == $past(pc_ff) + 32'd2)
      else $error("pc not advanced on fetch");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!rsp_chan.valid && !req_chan.ready))
      else $error("handshake during clear");
endmodule

>>> sim/tsx_tb_if.sv
`timescale 1ns / 100ps
package tsx_tb_pkg;
   typedef struct packed {
      logic        action;
      logic [15:0] instr;
      logic [9:0]  load_index;
      logic [31:0] load_word;
   } exec_item_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        flag_n;
      logic        flag_z;
      logic        flag_c;
      logic        flag_v;
      logic        thumb_state;
      logic        reg_written;
      logic [3:0]  reg_index;
      logic [31:0] reg_value;
      logic        last;
   } write_report_type;
endpackage

>>> sim/testbench.sv
`timescale 1ns / 100ps
module testbench;
   logic clock = 1'b0;
   logic reset = 1'b1;

   tsx_req_if req_chan ();
   tsx_rsp_if rsp_chan ();

   thumb_subset_execute_unit_core dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   logic [31:0]       arch_regs [16];
   tsx_pkg::flag_type arch_flags;
   logic [31:0]       arch_mem [tsx_pkg::DMEM_WORDS];
   logic [3:0]        wr_idx [$];
   logic [31:0]       wr_val [$];

   tsx_tb_pkg::exec_item_type    pending_items [$];
   tsx_tb_pkg::write_report_type expected_reports [$];
   int  mismatch_count = 0;
   bit  stimulus_done = 1'b0;
   bit  calm_phase = 1'b0;
   int  send_hold = 0;
   int  recv_hold = 0;

   function automatic logic [tsx_pkg::DMEM_AW-1:0] word_slot(logic [31:0] a);
      return a[tsx_pkg::DMEM_AW+1:2];
   endfunction

   function automatic void write_reg(logic [3:0] r, logic [31:0] v);
      arch_regs[r] = v;
      wr_idx.push_back(r);
      wr_val.push_back(v);
   endfunction

   function automatic void set_nz(logic [31:0] r);
      arch_flags.z = (r == 32'd0);
      arch_flags.n = r[31];
   endfunction

   function automatic logic [31:0] alu_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      set_nz(s[31:0]);
      arch_flags.c = s[32];
      arch_flags.v = (a[31] == b[31]) && (s[31] != a[31]);
      return s[31:0];
   endfunction

   function automatic logic [31:0] alu_sub(logic [31:0] a, logic [31:0] b);
      logic [31:0] r;
      r = a - b;
      set_nz(r);
      arch_flags.c = (a >= b);
      arch_flags.v = (a[31] != b[31]) && (r[31] != a[31]);
      return r;
   endfunction

   function automatic void branch_exchange(logic [31:0] t);
      arch_flags.t = t[0];
      write_reg(tsx_pkg::PC_REG, t[0] ? {t[31:1], 1'b0} : {t[31:2], 2'b00});
   endfunction

   function automatic bit cond_passes(logic [3:0] c);
      case (c)
         tsx_pkg::COND_EQ: return arch_flags.z;
         tsx_pkg::COND_NE: return !arch_flags.z;
         tsx_pkg::COND_CS: return arch_flags.c;
         tsx_pkg::COND_CC: return !arch_flags.c;
         tsx_pkg::COND_MI: return arch_flags.n;
         tsx_pkg::COND_PL: return !arch_flags.n;
         tsx_pkg::COND_VS: return arch_flags.v;
         tsx_pkg::COND_VC: return !arch_flags.v;
         tsx_pkg::COND_HI: return arch_flags.c && !arch_flags.z;
         tsx_pkg::COND_LS: return !arch_flags.c || arch_flags.z;
         tsx_pkg::COND_GE: return arch_flags.n == arch_flags.v;
         tsx_pkg::COND_LT: return arch_flags.n != arch_flags.v;
         tsx_pkg::COND_GT: return !arch_flags.z && (arch_flags.n == arch_flags.v);
         tsx_pkg::COND_LE: return arch_flags.z || (arch_flags.n != arch_flags.v);
         tsx_pkg::COND_AL: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic void run_instruction(logic [15:0] op);
      logic [31:0] pc, a, sp, w;
      logic [3:0]  hd, hs;
      logic [3:0]  l0, l3, l6, r8;
      logic [7:0]  imm8;
      logic [4:0]  imm5;
      int          cnt, sh;
      pc = arch_regs[tsx_pkg::PC_REG] + 32'd2;
      l0 = {1'b0, op[2:0]};
      l3 = {1'b0, op[5:3]};
      l6 = {1'b0, op[8:6]};
      hd = {op[7], op[2:0]};
      hs = {op[6], op[5:3]};
      r8 = {1'b0, op[10:8]};
      imm8 = op[7:0];
      imm5 = op[10:6];
      arch_regs[tsx_pkg::PC_REG] = pc;
      if (op[15:8] == 8'h44) begin
         write_reg(hd, arch_regs[hd] + arch_regs[hs]);
      end else if (op[15:8] == 8'h45) begin
         void'(alu_sub(arch_regs[hd], arch_regs[hs]));
      end else if (op[15:8] == 8'h46) begin
         write_reg(hd, arch_regs[hs]);
      end else if (op[15:8] == 8'h47) begin
         branch_exchange(arch_regs[hs]);
      end else if (op[15:9] == 7'b1011010) begin
         cnt = $countones(op[8:0]);
         sp = arch_regs[tsx_pkg::SP_REG] - 32'(cnt * 4);
         a = sp;
         for (int i = 0; i < 8; i++) begin
            if (imm8[i]) begin
               arch_mem[word_slot(a)] = arch_regs[i];
               a = a + 32'd4;
            end
         end
         if (op[8]) arch_mem[word_slot(a)] = arch_regs[tsx_pkg::LR_REG];
         write_reg(tsx_pkg::SP_REG, sp);
      end else if (op[15:9] == 7'b1011110) begin
         a = arch_regs[tsx_pkg::SP_REG];
         for (int i = 0; i < 8; i++) begin
            if (imm8[i]) begin
               write_reg(i[3:0], arch_mem[word_slot(a)]);
               a = a + 32'd4;
            end
         end
         if (op[8]) begin
            branch_exchange(arch_mem[word_slot(a)]);
            a = a + 32'd4;
         end
         write_reg(tsx_pkg::SP_REG, a);
      end else if (op[15:9] == 7'b0001100) begin
         write_reg(l0, alu_add(arch_regs[l3], arch_regs[l6]));
      end else if (op[15:9] == 7'b0001101) begin
         write_reg(l0, alu_sub(arch_regs[l3], arch_regs[l6]));
      end else if (op[15:9] == 7'b0001110) begin
         write_reg(l0, alu_add(arch_regs[l3], {28'd0, l6}));
      end else if (op[15:9] == 7'b0001111) begin
         write_reg(l0, alu_sub(arch_regs[l3], {28'd0, l6}));
      end else if (op[15:11] == 5'b00100) begin
         write_reg(r8, {24'd0, imm8});
         set_nz({24'd0, imm8});
      end else if (op[15:11] == 5'b00110) begin
         write_reg(r8, alu_add(arch_regs[r8], {24'd0, imm8}));
      end else if (op[15:11] == 5'b00111) begin
         write_reg(r8, alu_sub(arch_regs[r8], {24'd0, imm8}));
      end else if (op[15:11] == 5'b01001) begin
         a = ((pc + 32'd2) & ~32'd3) + {22'd0, imm8, 2'b00};
         write_reg(r8, arch_mem[word_slot(a)]);
         set_nz(arch_regs[r8]);
      end else if (op[15:11] == 5'b01100) begin
         a = arch_regs[l3] + {25'd0, imm5, 2'b00};
         sh = a[1:0] * 8;
         w = arch_regs[l0];
         arch_mem[word_slot(a)] = (w << sh) | ((sh == 0) ? 32'd0 : (w >> (32 - sh)));
      end else if (op[15:11] == 5'b01101) begin
         a = arch_regs[l3] + {25'd0, imm5, 2'b00};
         sh = a[1:0] * 8;
         w = arch_mem[word_slot(a)];
         write_reg(l0, (w >> sh) | ((sh == 0) ? 32'd0 : (w << (32 - sh))));
         set_nz(arch_regs[l0]);
      end else if (op[15:11] == 5'b01110) begin
         a = arch_regs[l3] + {27'd0, imm5};
         sh = a[1:0] * 8;
         w = arch_mem[word_slot(a)] & ~(32'hFF << sh);
         arch_mem[word_slot(a)] = w | ({24'd0, arch_regs[l0][7:0]} << sh);
      end else if (op[15:11] == 5'b01111) begin
         a = arch_regs[l3] + {27'd0, imm5};
         sh = a[1:0] * 8;
         write_reg(l0, (arch_mem[word_slot(a)] >> sh) & 32'hFF);
         set_nz(arch_regs[l0]);
      end else if (op[15:12] == 4'hD) begin
         if (cond_passes(op[11:8]))
            write_reg(tsx_pkg::PC_REG, pc + {{23{imm8[7]}}, imm8, 1'b0});
      end else if (op[15:11] == 5'b11100) begin
         write_reg(tsx_pkg::PC_REG, pc + {{20{op[10]}}, op[10:0], 1'b0});
      end
   endfunction

   function automatic void predict_item(tsx_tb_pkg::exec_item_type it);
      tsx_tb_pkg::write_report_type rep;
      int n;
      wr_idx.delete();
      wr_val.delete();
      if (it.action) arch_mem[it.load_index] = it.load_word;
      else run_instruction(it.instr);
      n = (wr_idx.size() == 0) ? 1 : wr_idx.size();
      for (int k = 0; k < n; k++) begin
         rep.next_pc = arch_regs[tsx_pkg::PC_REG];
         rep.flag_n = arch_flags.n;
         rep.flag_z = arch_flags.z;
         rep.flag_c = arch_flags.c;
         rep.flag_v = arch_flags.v;
         rep.thumb_state = arch_flags.t;
         rep.reg_written = (wr_idx.size() != 0);
         rep.reg_index = rep.reg_written ? wr_idx[k] : 4'd0;
         rep.reg_value = rep.reg_written ? wr_val[k] : 32'd0;
         rep.last = (k == n - 1);
         expected_reports.push_back(rep);
      end
   endfunction

   function automatic void queue_instr(logic [15:0] op);
      tsx_tb_pkg::exec_item_type it;
      it.action = 1'b0;
      it.instr = op;
      it.load_index = 10'($urandom);
      it.load_word = $urandom;
      pending_items.push_back(it);
   endfunction

   function automatic void queue_preload(logic [9:0] idx, logic [31:0] val);
      tsx_tb_pkg::exec_item_type it;
      it.action = 1'b1;
      it.instr = 16'($urandom);
      it.load_index = idx;
      it.load_word = val;
      pending_items.push_back(it);
   endfunction

   function automatic logic [15:0] random_instr();
      logic [15:0] r;
      r = 16'($urandom);
      case ($urandom_range(0, 11))
         0: r[15:11] = 5'b00100;
         1: r[15:11] = {4'b0011, r[11]};
         2: r[15:10] = 6'b010001;
         3: r[15:10] = 6'b000110;
         4: r[15:10] = 6'b000111;
         5: r[15:11] = 5'b01001;
         6: r[15:13] = 3'b011;
         7: r[15:12] = 4'hD;
         8: r[15:11] = 5'b11100;
         9: begin
            r[15:9] = $urandom_range(0, 1) ? 7'b1011010 : 7'b1011110;
         end
         10: r[15:12] = 4'hB;
         default: ;
      endcase
      return r;
   endfunction

   initial begin
      for (int i = 0; i < 16; i++) arch_regs[i] = 32'd0;
      for (int i = 0; i < tsx_pkg::DMEM_WORDS; i++) arch_mem[i] = 32'd0;
      arch_flags = '{n: 1'b0, z: 1'b0, c: 1'b0, v: 1'b0, t: 1'b1};
      queue_instr(16'h2000);
      queue_instr(16'h27FF);
      queue_instr(16'h1C79);
      queue_instr(16'h1FCA);
      queue_instr(16'h1853);
      queue_instr(16'h1A9C);
      queue_instr(16'h3BFF);
      queue_instr(16'h4468);
      queue_instr(16'h4540);
      queue_instr(16'h4681);
      queue_instr(16'h4700);
      queue_preload(10'd1023, 32'hFFFF_FFFF);
      queue_preload(10'd0, 32'h8765_4321);
      queue_instr(16'h4FFF);
      queue_instr(16'h6079);
      queue_instr(16'h6FFE);
      queue_instr(16'h7049);
      queue_instr(16'h7FC2);
      queue_instr(16'hB5FF);
      queue_instr(16'hBDFF);
      queue_instr(16'hB4AA);
      queue_instr(16'hBC55);
      queue_instr(16'hB800);
      queue_instr(16'hDE7F);
      queue_instr(16'hDF80);
      queue_instr(16'hE400);
      queue_instr(16'hE3FF);
      for (int i = 0; i < 200; i++) begin
         if ($urandom_range(0, 9) == 0)
            queue_preload(10'($urandom), $urandom);
         else
            queue_instr(random_instr());
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.action <= 1'b0;
         req_chan.instr <= 16'd0;
         req_chan.load_index <= 10'd0;
         req_chan.load_word <= 32'd0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_item({req_chan.action, req_chan.instr,
                          req_chan.load_index, req_chan.load_word});
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_hold > 0) begin
               send_hold <= send_hold - 1;
               req_chan.valid <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
               send_hold <= $urandom_range(0, 5);
               req_chan.valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               tsx_tb_pkg::exec_item_type it;
               it = pending_items.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.action <= it.action;
               req_chan.instr <= it.instr;
               req_chan.load_index <= it.load_index;
               req_chan.load_word <= it.load_word;
               calm_phase <= (pending_items.size() < 30);
            end else begin
               req_chan.valid <= 1'b0;
               stimulus_done <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            tsx_tb_pkg::write_report_type got, exp;
            got = {rsp_chan.next_pc, rsp_chan.flag_n, rsp_chan.flag_z, rsp_chan.flag_c,
                   rsp_chan.flag_v, rsp_chan.thumb_state, rsp_chan.reg_written,
                   rsp_chan.reg_index, rsp_chan.reg_value, rsp_chan.last};
            if (expected_reports.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected item: %p", got);
            end else begin
               exp = expected_reports.pop_front();
               if (got !== exp) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected %p got %p", exp, got);
               end
            end
         end
         if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
            recv_hold <= $urandom_range(0, 5);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      wait (stimulus_done);
      wait (expected_reports.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && expected_reports.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

>>> thumb_subset_execute_unit_core.f
design/tsx_pkg.sv
design/tsx_req_if.sv
design/tsx_rsp_if.sv
design/tsx_ram.sv
design/tsx_decode.sv
design/thumb_subset_execute_unit_core.sv
sim/tsx_tb_if.sv
sim/testbench.sv
